// File: design/path_canonicalizer_macros.svh
// Assertion macros shared by the checker.
`ifndef PATH_CANONICALIZER_MACROS_SVH
`define PATH_CANONICALIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pc_pkg.sv
package pc_pkg;

  localparam int DEF_MAX_NAME = 63;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CHAR_SEP  = 8'h2F;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_NULL = 8'h00;

  // One classified input item as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] ch;
    logic       keep;
    logic       last;
    logic       op;
  } q_item_t;

endpackage

// File: design/pc_front.sv
module pc_front #(
  parameter int MAX_NAME = pc_pkg::DEF_MAX_NAME
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        path_char,
  input  logic              last_char,
  input  logic              operation,
  output pc_pkg::q_item_t   item
);
  import pc_pkg::*;

  localparam int PW = $clog2(MAX_NAME + 1);

  logic [PW-1:0] cnt_r, cnt_nxt;
  logic          zero_r, zero_nxt;
  logic          room;

  // A byte is kept while there is room and no terminating zero was seen.
  assign room = (cnt_r < PW'(MAX_NAME));

  always_comb begin
    item.ch   = path_char;
    item.keep = room && !zero_r && (path_char != CHAR_NULL);
    item.last = last_char;
    item.op   = operation;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    if (accept) begin
      if (last_char) begin
        cnt_nxt  = '0;
        zero_nxt = 1'b0;
      end else begin
        if (room) begin
          cnt_nxt = cnt_r + PW'(1);
        end
        if (path_char == CHAR_NULL) begin
          zero_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
  end

endmodule

// File: design/pc_queue.sv
module pc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pc_pkg::q_item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output pc_pkg::q_item_t head
);
  import pc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t       slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: design/pc_back.sv
module pc_back #(
  parameter int MAX_NAME = pc_pkg::DEF_MAX_NAME
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  pc_pkg::q_item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic            out_status
);
  import pc_pkg::*;

  localparam int PW     = $clog2(MAX_NAME + 1);
  localparam int WDEPTH = 2 * (MAX_NAME + 1);
  localparam int WW     = $clog2(WDEPTH);
  localparam int LW     = WW + 1;

  localparam logic [4:0] S_COLL   = 5'd0;
  localparam logic [4:0] S_CWD_RD = 5'd1;
  localparam logic [4:0] S_CWD_WR = 5'd2;
  localparam logic [4:0] S_PS_RD  = 5'd3;
  localparam logic [4:0] S_PS_WR  = 5'd4;
  localparam logic [4:0] S_P1_RD  = 5'd5;
  localparam logic [4:0] S_P1_EV  = 5'd6;
  localparam logic [4:0] S_P1_END = 5'd7;
  localparam logic [4:0] S_BS_RD  = 5'd8;
  localparam logic [4:0] S_BS_EV  = 5'd9;
  localparam logic [4:0] S_SP_RD  = 5'd10;
  localparam logic [4:0] S_SP_WR  = 5'd11;
  localparam logic [4:0] S_P2_RD  = 5'd12;
  localparam logic [4:0] S_P2_EV  = 5'd13;
  localparam logic [4:0] S_TR_RD  = 5'd14;
  localparam logic [4:0] S_TR_EV  = 5'd15;
  localparam logic [4:0] S_EM_CHK = 5'd16;
  localparam logic [4:0] S_EM_RD  = 5'd17;
  localparam logic [4:0] S_EM_WR  = 5'd18;

  localparam logic [1:0] RET_P1   = 2'd0;
  localparam logic [1:0] RET_P2   = 2'd1;
  localparam logic [1:0] RET_P2C  = 2'd2;

  // Storage: collected path, work buffer and current directory.
  logic [7:0] pstore [MAX_NAME + 1];
  logic [7:0] wbuf   [WDEPTH];
  logic [7:0] cwd    [MAX_NAME + 1];

  logic [4:0]    st_r, st_nxt;
  logic [PW-1:0] plen_r, plen_nxt, i_r, i_nxt;
  logic          rel_r, rel_nxt, op_r, op_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt, c_r, c_nxt, p_r, p_nxt;
  logic [LW-1:0] s_r, s_nxt, d_r, d_nxt, dst_r, dst_nxt, src_r, src_nxt;
  logic          dcnt_r, dcnt_nxt;
  logic [1:0]    ret_r, ret_nxt;
  logic          md_r, md_nxt, mdd_r, mdd_nxt, sl_r, sl_nxt;
  logic [7:0]    lastch_r, lastch_nxt;
  logic [PW-1:0] cwd_len_r, cwd_len_nxt;
  logic          cwd_sep_r, cwd_sep_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt, os_r, os_nxt;
  logic [7:0]    oc_r, oc_nxt;

  logic          ps_we, wb_we, cwd_we;
  logic [PW-1:0] ps_waddr, ps_raddr, cwd_waddr, cwd_raddr;
  logic [WW-1:0] wb_waddr, wb_raddr;
  logic [7:0]    ps_wdata, wb_wdata, cwd_wdata;
  logic [7:0]    ps_rdata_r, wb_rdata_r, cwd_rdata_r;
  logic          rel_now, bs_done;
  logic [LW-1:0] bs_p;

  assign out_valid  = ov_r;
  assign out_char   = oc_r;
  assign out_last   = ol_r;
  assign out_status = os_r;

  always_comb begin
    st_nxt      = st_r;
    plen_nxt    = plen_r;
    i_nxt       = i_r;
    rel_nxt     = rel_r;
    op_nxt      = op_r;
    wlen_nxt    = wlen_r;
    c_nxt       = c_r;
    p_nxt       = p_r;
    s_nxt       = s_r;
    d_nxt       = d_r;
    dst_nxt     = dst_r;
    src_nxt     = src_r;
    dcnt_nxt    = dcnt_r;
    ret_nxt     = ret_r;
    md_nxt      = md_r;
    mdd_nxt     = mdd_r;
    sl_nxt      = sl_r;
    lastch_nxt  = lastch_r;
    cwd_len_nxt = cwd_len_r;
    cwd_sep_nxt = cwd_sep_r;
    ov_nxt      = 1'b0;
    oc_nxt      = oc_r;
    ol_nxt      = ol_r;
    os_nxt      = os_r;
    q_pop       = 1'b0;
    ps_we       = 1'b0;
    ps_waddr    = plen_r;
    ps_wdata    = q_item.ch;
    ps_raddr    = i_r;
    wb_we       = 1'b0;
    wb_waddr    = wlen_r[WW-1:0];
    wb_wdata    = CHAR_SEP;
    wb_raddr    = c_r[WW-1:0];
    cwd_we      = 1'b0;
    cwd_waddr   = c_r[PW-1:0];
    cwd_wdata   = wb_rdata_r;
    cwd_raddr   = i_r;
    rel_now     = rel_r;
    bs_done     = 1'b0;
    bs_p        = p_r;

    case (st_r)
      S_COLL: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (plen_r == '0) begin
            rel_now = q_item.keep ? (q_item.ch != CHAR_SEP) : 1'b1;
          end
          rel_nxt = rel_now;
          if (q_item.keep) begin
            ps_we    = 1'b1;
            plen_nxt = plen_r + PW'(1);
          end
          if (q_item.last) begin
            op_nxt   = q_item.op;
            wlen_nxt = '0;
            i_nxt    = '0;
            st_nxt   = rel_now ? S_CWD_RD : S_PS_RD;
          end
        end
      end
      S_CWD_RD: begin
        if (i_r < cwd_len_r) begin
          st_nxt = S_CWD_WR;
        end else begin
          if ((cwd_len_r == '0) || !cwd_sep_r) begin
            wb_we    = 1'b1;
            wlen_nxt = wlen_r + LW'(1);
          end
          i_nxt  = '0;
          st_nxt = S_PS_RD;
        end
      end
      S_CWD_WR: begin
        wb_we    = 1'b1;
        wb_wdata = cwd_rdata_r;
        wlen_nxt = wlen_r + LW'(1);
        i_nxt    = i_r + PW'(1);
        st_nxt   = S_CWD_RD;
      end
      S_PS_RD: begin
        if (i_r < plen_r) begin
          st_nxt = S_PS_WR;
        end else begin
          c_nxt   = '0;
          md_nxt  = 1'b0;
          mdd_nxt = 1'b0;
          sl_nxt  = 1'b0;
          st_nxt  = S_P1_RD;
        end
      end
      S_PS_WR: begin
        wb_we    = 1'b1;
        wb_wdata = ps_rdata_r;
        wlen_nxt = wlen_r + LW'(1);
        i_nxt    = i_r + PW'(1);
        st_nxt   = S_PS_RD;
      end
      S_P1_RD: begin
        st_nxt = (c_r < wlen_r) ? S_P1_EV : S_P1_END;
      end
      S_P1_EV: begin
        if (wb_rdata_r == CHAR_DOT) begin
          mdd_nxt = sl_r && md_r;
          md_nxt  = sl_r && !(sl_r && md_r);
          c_nxt   = c_r + LW'(1);
          st_nxt  = S_P1_RD;
        end else if (wb_rdata_r == CHAR_SEP) begin
          sl_nxt = 1'b1;
          if (md_r || mdd_r) begin
            // A "." or ".." segment just closed: remove it.
            md_nxt   = 1'b0;
            mdd_nxt  = 1'b0;
            p_nxt    = c_r;
            dcnt_nxt = mdd_r;
            src_nxt  = c_r + LW'(1);
            ret_nxt  = RET_P1;
            st_nxt   = S_BS_RD;
          end else begin
            c_nxt  = c_r + LW'(1);
            st_nxt = S_P1_RD;
          end
        end else begin
          md_nxt  = 1'b0;
          mdd_nxt = 1'b0;
          sl_nxt  = 1'b0;
          c_nxt   = c_r + LW'(1);
          st_nxt  = S_P1_RD;
        end
      end
      S_P1_END: begin
        if (mdd_r || md_r) begin
          p_nxt    = wlen_r;
          dcnt_nxt = mdd_r;
          src_nxt  = wlen_r;
          ret_nxt  = RET_P2;
          st_nxt   = S_BS_RD;
        end else begin
          c_nxt  = '0;
          st_nxt = S_P2_RD;
        end
      end
      S_BS_RD: begin
        if (p_r == '0) begin
          bs_done = 1'b1;
          bs_p    = p_r;
        end else begin
          p_nxt    = p_r - LW'(1);
          wb_raddr = WW'(p_r - LW'(1));
          st_nxt   = S_BS_EV;
        end
      end
      S_BS_EV: begin
        if (wb_rdata_r == CHAR_SEP) begin
          bs_done = 1'b1;
          bs_p    = p_r;
        end else begin
          st_nxt = S_BS_RD;
        end
      end
      S_SP_RD: begin
        if (s_r < wlen_r) begin
          wb_raddr = s_r[WW-1:0];
          st_nxt   = S_SP_WR;
        end else begin
          if (d_r < wlen_r) begin
            wlen_nxt = d_r;
          end
          case (ret_r)
            RET_P1: begin
              c_nxt  = dst_r;
              st_nxt = S_P1_RD;
            end
            RET_P2: begin
              c_nxt  = '0;
              st_nxt = S_P2_RD;
            end
            default: begin
              c_nxt  = dst_r;
              st_nxt = S_P2_RD;
            end
          endcase
        end
      end
      S_SP_WR: begin
        wb_we    = 1'b1;
        wb_waddr = d_r[WW-1:0];
        wb_wdata = wb_rdata_r;
        d_nxt    = d_r + LW'(1);
        s_nxt    = s_r + LW'(1);
        st_nxt   = S_SP_RD;
      end
      S_P2_RD: begin
        st_nxt = (c_r < wlen_r) ? S_P2_EV : S_TR_RD;
      end
      S_P2_EV: begin
        if (wb_rdata_r == CHAR_SEP) begin
          sl_nxt = 1'b1;
          if (sl_r) begin
            p_nxt    = c_r;
            dcnt_nxt = 1'b0;
            src_nxt  = c_r + LW'(1);
            ret_nxt  = RET_P2C;
            st_nxt   = S_BS_RD;
          end else begin
            c_nxt  = c_r + LW'(1);
            st_nxt = S_P2_RD;
          end
        end else begin
          sl_nxt = 1'b0;
          c_nxt  = c_r + LW'(1);
          st_nxt = S_P2_RD;
        end
      end
      S_TR_RD: begin
        if (wlen_r > LW'(1)) begin
          wb_raddr = WW'(wlen_r - LW'(1));
          st_nxt   = S_TR_EV;
        end else begin
          st_nxt = S_EM_CHK;
        end
      end
      S_TR_EV: begin
        if (wb_rdata_r == CHAR_SEP) begin
          wlen_nxt = wlen_r - LW'(1);
        end
        st_nxt = S_EM_CHK;
      end
      S_EM_CHK: begin
        c_nxt = '0;
        if (wlen_r > LW'(MAX_NAME)) begin
          ov_nxt   = 1'b1;
          oc_nxt   = CHAR_NULL;
          ol_nxt   = 1'b1;
          os_nxt   = 1'b1;
          plen_nxt = '0;
          st_nxt   = S_COLL;
        end else begin
          st_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        if (c_r < wlen_r) begin
          st_nxt = S_EM_WR;
        end else begin
          if (op_r) begin
            cwd_len_nxt = ((wlen_r == LW'(1)) && (lastch_r == CHAR_SEP)) ? '0
                          : wlen_r[PW-1:0];
            cwd_sep_nxt = (lastch_r == CHAR_SEP);
          end
          plen_nxt = '0;
          st_nxt   = S_COLL;
        end
      end
      S_EM_WR: begin
        ov_nxt     = 1'b1;
        oc_nxt     = wb_rdata_r;
        ol_nxt     = ((c_r + LW'(1)) == wlen_r);
        os_nxt     = 1'b0;
        cwd_we     = op_r;
        lastch_nxt = wb_rdata_r;
        c_nxt      = c_r + LW'(1);
        st_nxt     = S_EM_RD;
      end
      default: begin
        st_nxt = S_COLL;
      end
    endcase

    // End of a backward search for a separator.
    if (bs_done) begin
      if (dcnt_r) begin
        dcnt_nxt = 1'b0;
        p_nxt    = bs_p;
        st_nxt   = S_BS_RD;
      end else begin
        d_nxt   = bs_p + LW'(1);
        dst_nxt = bs_p + LW'(1);
        s_nxt   = src_r;
        st_nxt  = S_SP_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ps_we) begin
      pstore[ps_waddr] <= ps_wdata;
    end
    ps_rdata_r <= pstore[ps_raddr];
  end

  always_ff @(posedge clk) begin
    if (wb_we) begin
      wbuf[wb_waddr] <= wb_wdata;
    end
    wb_rdata_r <= wbuf[wb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cwd_we) begin
      cwd[cwd_waddr] <= cwd_wdata;
    end
    cwd_rdata_r <= cwd[cwd_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_COLL;
      plen_r    <= '0;
      rel_r     <= 1'b1;
      cwd_len_r <= '0;
      cwd_sep_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      plen_r    <= plen_nxt;
      rel_r     <= rel_nxt;
      cwd_len_r <= cwd_len_nxt;
      cwd_sep_r <= cwd_sep_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    op_r     <= op_nxt;
    wlen_r   <= wlen_nxt;
    c_r      <= c_nxt;
    p_r      <= p_nxt;
    s_r      <= s_nxt;
    d_r      <= d_nxt;
    dst_r    <= dst_nxt;
    src_r    <= src_nxt;
    dcnt_r   <= dcnt_nxt;
    ret_r    <= ret_nxt;
    md_r     <= md_nxt;
    mdd_r    <= mdd_nxt;
    sl_r     <= sl_nxt;
    lastch_r <= lastch_nxt;
    oc_r     <= oc_nxt;
    ol_r     <= ol_nxt;
    os_r     <= os_nxt;
  end

endmodule

// File: design/path_canonicalizer.sv
// Channel  | Ports                                            | Handshake
// input    | in_path_char, in_last_char, in_operation         | start high, busy low
// result   | out_char, out_last, out_status                   | out_valid for one cycle
//
// Items enter one per cycle until the four-entry queue fills; busy is the full flag.
// On the last item of a path the back end builds the absolute path, then runs the
// dot, slash and trailing-slash passes over a work buffer with one read and one
// write port, reading and then evaluating each visited byte.
// Reset is synchronous and clears the control state and the stored directory length.
// The receiver cannot stall, so results are never held back.
module path_canonicalizer #(
  parameter int MAX_NAME = pc_pkg::DEF_MAX_NAME
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_path_char,
  input  logic       in_last_char,
  input  logic       in_operation,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_status
);
  import pc_pkg::*;

  q_item_t front_item, head_item;
  logic    accept, q_full, q_ne, q_pop;

  // An item is taken whenever start is high and the queue has room.
  assign busy   = q_full;
  assign accept = start && !q_full;

  // The front end counts bytes and marks which ones belong to the path.
  pc_front #(.MAX_NAME(MAX_NAME)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .path_char (in_path_char),
    .last_char (in_last_char),
    .operation (in_operation),
    .item      (front_item)
  );

  pc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_ne),
    .head      (head_item)
  );

  // The back end owns the path store, work buffer and current directory.
  pc_back #(.MAX_NAME(MAX_NAME)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_ne),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

// File: design/pc_checker.sv
`include "path_canonicalizer_macros.svh"

module pc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_path_char,
  input logic       in_last_char,
  input logic       in_operation,
  input logic       out_valid,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_status
);

  // An error result stands alone and carries a zero byte.
  `PC_ASSERT_NOW(a_err_alone, out_valid && out_status, out_last && (out_char == 8'h00), "error item malformed")

  // No result byte follows directly on a byte that is not the last of its path.
  `PC_ASSERT_NEXT(a_spacing, out_valid && !out_last, !out_valid, "result items too close")

  // Nothing is emitted right after reset.
  `PC_ASSERT_NOW(a_rst_quiet, $past(!rst_n), !out_valid, "result item after reset")

endmodule

bind path_canonicalizer pc_checker u_pc_checker (.*);
